// ===== hdl/tcr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared constants for the text console renderer: request kinds, register
// indexes, reset values and default geometry.
// ----------------------------------------------------------------------------
package tcr_pkg;

	// request kinds carried on tuser
	localparam logic [2:0] REQ_PUT_CHAR   = 3'd0;
	localparam logic [2:0] REQ_LOAD_GLYPH = 3'd1;
	localparam logic [2:0] REQ_SET_CURSOR = 3'd2;
	localparam logic [2:0] REQ_CLEAR      = 3'd3;
	localparam logic [2:0] REQ_READ_PIXEL = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_FG_COLOR      = 2'd2;
	localparam logic [1:0] CFG_BG_COLOR      = 2'd3;

	localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd640;
	localparam logic [9:0]  RST_SCREEN_HEIGHT = 10'd480;
	localparam logic [31:0] RST_FG_COLOR      = 32'hFFFF_FFFF;
	localparam logic [31:0] RST_BG_COLOR      = 32'h0000_0000;

	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam int         CELL_W       = 8;

	// working width for pixel coordinates, sums and limits over the geometry range
	localparam int DIM_W = 13;

	localparam int DEF_MAX_WIDTH    = 1024;
	localparam int DEF_MAX_HEIGHT   = 512;
	localparam int DEF_GLYPH_HEIGHT = 8;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 56;

endpackage

// ===== hdl/text_console_renderer.sv =====
// ----------------------------------------------------------------------------
// text_console_renderer
// Text console drawing glyphs into a single-ported-write pixel frame store,
// with cursor handling, wrap, newline and scroll.
//
//  channel   | direction | signals
//  ----------+-----------+-----------------------------------------------
//  s_axis    | in        | tvalid, tready, tdata (fields), tuser (request)
//  m_axis    | out       | tvalid, tready, tdata (pixel, cursor, scrolled)
//  cfg       | in        | cfg_we, cfg_addr, cfg_wdata
//
// Put char: each glyph row is one glyph store read and eight pixel
// writes. A scroll moves one pixel per cycle
// through the frame store ports. Clear walks all
// MAX_WIDTH*MAX_HEIGHT entries, one per cycle; the same pass runs after reset
// (no request taken meanwhile). A write to screen_height holds off requests
// while the text limit is recomputed. A result waiting on m_axis does not
// stop the next request from being taken.
// ----------------------------------------------------------------------------
module text_console_renderer
	import tcr_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// char_code, glyph_row, glyph_bits, cursor_col, cursor_row, pixel_x, pixel_y
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// req_type
	input  logic [2:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// pixel_data, cursor_x, cursor_y, scrolled
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [31:0]           cfg_wdata
);

	localparam int FS_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int FS_AW    = $clog2(FS_DEPTH);
	localparam int G_DEPTH  = 256 * GLYPH_HEIGHT;
	localparam int G_AW     = $clog2(G_DEPTH);
	localparam int GRW      = $clog2(GLYPH_HEIGHT);

	localparam logic [DIM_W-1:0] GH_D = DIM_W'(GLYPH_HEIGHT);
	localparam logic [DIM_W-1:0] MW_D = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MH_D = DIM_W'(MAX_HEIGHT);
	localparam logic [DIM_W-1:0] CW_D = DIM_W'(CELL_W);

	localparam logic [3:0] ST_SWEEP  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_GREAD  = 4'd2;
	localparam logic [3:0] ST_GDRAW  = 4'd3;
	localparam logic [3:0] ST_ADV    = 4'd4;
	localparam logic [3:0] ST_SCOPY  = 4'd5;
	localparam logic [3:0] ST_SDRAIN = 4'd6;
	localparam logic [3:0] ST_SFILL  = 4'd7;
	localparam logic [3:0] ST_PCAP   = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	function automatic logic [FS_AW-1:0] fs_addr(input logic [DIM_W-1:0] y,
		input logic [DIM_W-1:0] x);
		fs_addr = FS_AW'(32'(y) * MAX_WIDTH + 32'(x));
	endfunction

	// request fields
	logic [7:0] in_char;
	logic [3:0] in_grow;
	logic [7:0] in_gbits;
	logic [6:0] in_col;
	logic [5:0] in_row;
	logic [9:0] in_px;
	logic [8:0] in_py;

	assign in_char  = s_axis_tdata[7:0];
	assign in_grow  = s_axis_tdata[11:8];
	assign in_gbits = s_axis_tdata[19:12];
	assign in_col   = s_axis_tdata[26:20];
	assign in_row   = s_axis_tdata[32:27];
	assign in_px    = s_axis_tdata[42:33];
	assign in_py    = s_axis_tdata[51:43];

	// registers
	logic [3:0]       st_q;
	logic [10:0]      scr_w_q;
	logic [9:0]       scr_h_q;
	logic [31:0]      fg_q;
	logic [31:0]      bg_q;
	logic [DIM_W-1:0] lim_q;
	logic             lim_busy_q;
	logic [9:0]       cur_x_q;
	logic [8:0]       cur_y_q;
	logic [7:0]       ch_q;
	logic             nl_q;
	logic             clr_q;
	logic [GRW-1:0]   gr_q;
	logic [2:0]       gc_q;
	logic [DIM_W-1:0] sx_q;
	logic [DIM_W-1:0] sy_q;
	logic [FS_AW-1:0] sweep_q;
	logic             inside_q;
	logic [31:0]      pix_q;
	logic             scr_q;
	logic             m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic             cp_v_s1;
	logic [FS_AW-1:0] cp_addr_s1;

	// memories
	logic [31:0]      fs_mem [FS_DEPTH];
	logic [31:0]      fs_rd_q;
	logic [7:0]       g_mem [G_DEPTH];
	logic [7:0]       g_rd_q;

	logic             fs_we, fs_re, g_we, g_re;
	logic [FS_AW-1:0] fs_waddr, fs_raddr;
	logic [31:0]      fs_wdata;
	logic [G_AW-1:0]  g_waddr, g_raddr;

	logic [DIM_W-1:0] eff_w, eff_h;
	logic             accept;
	logic             in_inside;
	logic [DIM_W-1:0] gx, gy;
	logic [DIM_W-1:0] ax1, ay1, ax2, ay2;
	logic             a_wrap, a_below;

	assign eff_w = (DIM_W'(scr_w_q) < MW_D) ? DIM_W'(scr_w_q) : MW_D;
	assign eff_h = (DIM_W'(scr_h_q) < MH_D) ? DIM_W'(scr_h_q) : MH_D;

	assign s_axis_tready = (st_q == ST_IDLE) && !lim_busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_inside     = (DIM_W'(in_px) < eff_w) && (DIM_W'(in_py) < eff_h);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// pixel under the glyph sequencer, leftmost column first
	assign gx = DIM_W'(cur_x_q) + DIM_W'(gc_q);
	assign gy = DIM_W'(cur_y_q) + DIM_W'(gr_q);

	// cursor advance after a put char
	always_comb begin
		ax1     = nl_q ? '0 : DIM_W'(cur_x_q) + CW_D;
		ay1     = nl_q ? DIM_W'(cur_y_q) + GH_D : DIM_W'(cur_y_q);
		a_wrap  = ax1 >= eff_w;
		ax2     = a_wrap ? '0 : ax1;
		ay2     = a_wrap ? ay1 + GH_D : ay1;
		a_below = ay2 >= lim_q;
	end

	// frame store and glyph store port control
	always_comb begin
		fs_we    = 1'b0;
		fs_waddr = '0;
		fs_wdata = '0;
		fs_re    = 1'b0;
		fs_raddr = fs_addr(DIM_W'(in_py), DIM_W'(in_px));
		g_we     = accept && (s_axis_tuser == REQ_LOAD_GLYPH)
			&& (32'(in_grow) < GLYPH_HEIGHT);
		g_waddr  = G_AW'(32'(in_char) * GLYPH_HEIGHT + 32'(in_grow));
		g_re     = (st_q == ST_GREAD);
		g_raddr  = G_AW'(32'(ch_q) * GLYPH_HEIGHT + 32'(gr_q));
		if (cp_v_s1) begin
			fs_we    = 1'b1;
			fs_waddr = cp_addr_s1;
			fs_wdata = fs_rd_q;
		end else begin
			case (st_q)
				ST_SWEEP: begin
					fs_we    = 1'b1;
					fs_waddr = sweep_q;
				end
				ST_GDRAW: begin
					fs_we    = (gx < eff_w) && (gy < eff_h);
					fs_waddr = fs_addr(gy, gx);
					fs_wdata = g_rd_q[3'd7 - gc_q] ? fg_q : bg_q;
				end
				ST_SFILL: begin
					fs_we    = 1'b1;
					fs_waddr = fs_addr(sy_q, sx_q);
					fs_wdata = bg_q;
				end
				default: ;
			endcase
		end
		if (st_q == ST_SCOPY) begin
			fs_re    = 1'b1;
			fs_raddr = fs_addr(sy_q + GH_D, sx_q);
		end else if (accept && (s_axis_tuser == REQ_READ_PIXEL) && in_inside) begin
			fs_re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_waddr] <= fs_wdata;
		end
		if (fs_re) begin
			fs_rd_q <= fs_mem[fs_raddr];
		end
		if (g_we) begin
			g_mem[g_waddr] <= in_gbits;
		end
		if (g_re) begin
			g_rd_q <= g_mem[g_raddr];
		end
	end

	// configuration and text limit (largest multiple of the glyph height in the screen)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q    <= RST_SCREEN_WIDTH;
			scr_h_q    <= RST_SCREEN_HEIGHT;
			fg_q       <= RST_FG_COLOR;
			bg_q       <= RST_BG_COLOR;
			lim_q      <= '0;
			lim_busy_q <= 1'b1;
		end else begin
			if (lim_busy_q) begin
				if (lim_q + GH_D <= eff_h) begin
					lim_q <= lim_q + GH_D;
				end else begin
					lim_busy_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_SCREEN_WIDTH:  scr_w_q <= cfg_wdata[10:0];
					CFG_SCREEN_HEIGHT: begin
						scr_h_q    <= cfg_wdata[9:0];
						lim_q      <= '0;
						lim_busy_q <= 1'b1;
					end
					CFG_FG_COLOR:      fg_q <= cfg_wdata;
					CFG_BG_COLOR:      bg_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q     <= in_char;
			nl_q     <= (in_char == CHAR_NEWLINE);
			inside_q <= in_inside;
		end
		if (st_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
			m_data_q <= OUT_DATA_W'({scr_q, cur_y_q, cur_x_q, pix_q});
		end
		cp_addr_s1 <= fs_addr(sy_q, sx_q);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_SWEEP;
			sweep_q   <= '0;
			clr_q     <= 1'b0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			gr_q      <= '0;
			gc_q      <= '0;
			sx_q      <= '0;
			sy_q      <= '0;
			pix_q     <= '0;
			scr_q     <= 1'b0;
			m_valid_q <= 1'b0;
			cp_v_s1   <= 1'b0;
		end else begin
			cp_v_s1 <= (st_q == ST_SCOPY);
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_SWEEP: begin
					if (32'(sweep_q) == FS_DEPTH - 1) begin
						sweep_q <= '0;
						st_q    <= clr_q ? ST_DONE : ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						pix_q <= '0;
						scr_q <= 1'b0;
						clr_q <= 1'b0;
						gr_q  <= '0;
						gc_q  <= '0;
						case (s_axis_tuser)
							REQ_PUT_CHAR: begin
								st_q <= (in_char == CHAR_NEWLINE) ? ST_ADV : ST_GREAD;
							end
							REQ_SET_CURSOR: begin
								cur_x_q <= {in_col, 3'b000};
								cur_y_q <= 9'(DIM_W'(in_row) * GH_D);
								st_q    <= ST_DONE;
							end
							REQ_CLEAR: begin
								cur_x_q <= '0;
								cur_y_q <= '0;
								clr_q   <= 1'b1;
								st_q    <= ST_SWEEP;
							end
							REQ_READ_PIXEL: st_q <= ST_PCAP;
							default:        st_q <= ST_DONE;
						endcase
					end
				end
				ST_GREAD: st_q <= ST_GDRAW;
				ST_GDRAW: begin
					gc_q <= gc_q + 1'b1;
					if (gc_q == 3'd7) begin
						gr_q <= gr_q + 1'b1;
						st_q <= (32'(gr_q) == GLYPH_HEIGHT - 1) ? ST_ADV : ST_GREAD;
					end
				end
				ST_ADV: begin
					sx_q <= '0;
					sy_q <= '0;
					if (a_below) begin
						cur_x_q <= '0;
						if (lim_q == '0) begin
							cur_y_q <= '0;
							st_q    <= ST_DONE;
						end else begin
							cur_y_q <= 9'(lim_q - GH_D);
							scr_q   <= 1'b1;
							st_q    <= (eff_w == '0 || lim_q <= GH_D) ? ST_SDRAIN : ST_SCOPY;
						end
					end else begin
						cur_x_q <= ax2[9:0];
						cur_y_q <= ay2[8:0];
						st_q    <= ST_DONE;
					end
				end
				ST_SCOPY: begin
					if (sx_q == eff_w - 1'b1) begin
						sx_q <= '0;
						if (sy_q + GH_D + 1'b1 >= lim_q) begin
							st_q <= ST_SDRAIN;
						end else begin
							sy_q <= sy_q + 1'b1;
						end
					end else begin
						sx_q <= sx_q + 1'b1;
					end
				end
				ST_SDRAIN: begin
					// last copy write lands here; then wipe the bottom text line
					sx_q <= '0;
					sy_q <= lim_q - GH_D;
					st_q <= (eff_w == '0) ? ST_DONE : ST_SFILL;
				end
				ST_SFILL: begin
					if (sx_q == eff_w - 1'b1) begin
						sx_q <= '0;
						if (sy_q == lim_q - 1'b1) begin
							st_q <= ST_DONE;
						end else begin
							sy_q <= sy_q + 1'b1;
						end
					end else begin
						sx_q <= sx_q + 1'b1;
					end
				end
				ST_PCAP: begin
					pix_q <= inside_q ? fs_rd_q : '0;
					st_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						st_q      <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_glyph_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_GDRAW && fs_we && !cp_v_s1) |-> (gx < eff_w && gy < eff_h))
		else $error("glyph pixel written outside the screen");

	a_scroll_home: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[51]) |-> (m_axis_tdata[41:32] == 10'd0))
		else $error("scroll reported with cursor off the left margin");

	a_copy_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_v_s1 && fs_re) |-> (cp_addr_s1 != fs_raddr))
		else $error("scroll copy writes the pixel it is reading");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!lim_busy_q |-> (lim_q <= eff_h && lim_q + GH_D > eff_h))
		else $error("text limit out of step with screen height");
`endif

endmodule
